### rtl/lav_pkg.sv
package lav_pkg;

  localparam int DATA_W    = 32;
  localparam int MAG_BITS  = 31;  // normalized magnitude, top one lands in bit 30
  localparam int FRAC_BITS = 30;  // Q2.30 result scale
  localparam int ROOT_BITS = 32;
  localparam int QUO_BITS  = 31;
  localparam int SUM_BITS  = 64;

  localparam logic signed [DATA_W-1:0] Q30_ONE = 32'sh4000_0000;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [DATA_W-1:0] eye_x;
    logic signed [DATA_W-1:0] eye_y;
    logic signed [DATA_W-1:0] eye_z;
    logic signed [DATA_W-1:0] target_x;
    logic signed [DATA_W-1:0] target_y;
    logic signed [DATA_W-1:0] target_z;
    logic signed [DATA_W-1:0] up_x;
    logic signed [DATA_W-1:0] up_y;
    logic signed [DATA_W-1:0] up_z;
  } lav_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] side_x;
    logic signed [DATA_W-1:0] side_y;
    logic signed [DATA_W-1:0] side_z;
    logic signed [DATA_W-1:0] true_up_x;
    logic signed [DATA_W-1:0] true_up_y;
    logic signed [DATA_W-1:0] true_up_z;
    logic signed [DATA_W-1:0] back_x;
    logic signed [DATA_W-1:0] back_y;
    logic signed [DATA_W-1:0] back_z;
    logic signed [DATA_W-1:0] shift_x;
    logic signed [DATA_W-1:0] shift_y;
    logic signed [DATA_W-1:0] shift_z;
  } lav_out_t;

  function automatic logic [DATA_W-1:0] sat_neg(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v == S32_MIN) begin
      r = S32_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

### rtl/lav_cross.sv
module lav_cross
  import lav_pkg::*;
#(
  parameter int PW = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2:0][DATA_W-1:0]   in_a,
  input  logic [2:0][DATA_W-1:0]   in_b,
  input  logic [PW-1:0]            in_pay,
  output logic                     out_valid,
  output logic [2:0][2*DATA_W-1:0] out_vec,
  output logic [PW-1:0]            out_pay
);

  logic signed [2*DATA_W-1:0] prod_nxt [6];
  logic signed [2*DATA_W-1:0] prod_r   [6];
  logic [PW-1:0]              pay1_r, pay2_r;
  logic                       vld1_r, vld2_r;
  logic [2:0][2*DATA_W-1:0]   vec2_r;

  assign prod_nxt[0] = $signed(in_a[1]) * $signed(in_b[2]);
  assign prod_nxt[1] = $signed(in_a[2]) * $signed(in_b[1]);
  assign prod_nxt[2] = $signed(in_a[2]) * $signed(in_b[0]);
  assign prod_nxt[3] = $signed(in_a[0]) * $signed(in_b[2]);
  assign prod_nxt[4] = $signed(in_a[0]) * $signed(in_b[1]);
  assign prod_nxt[5] = $signed(in_a[1]) * $signed(in_b[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      pay1_r    <= in_pay;
      vec2_r[0] <= prod_r[0] - prod_r[1];
      vec2_r[1] <= prod_r[2] - prod_r[3];
      vec2_r[2] <= prod_r[4] - prod_r[5];
      pay2_r    <= pay1_r;
    end
  end

  assign out_valid = vld2_r;
  assign out_vec   = vec2_r;
  assign out_pay   = pay2_r;

endmodule

### rtl/lav_norm.sv
module lav_norm
  import lav_pkg::*;
#(
  parameter int W  = 33,
  parameter int PW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0][W-1:0]      in_vec,
  input  logic [PW-1:0]          in_pay,
  output logic                   out_valid,
  output logic [2:0][DATA_W-1:0] out_vec,
  output logic [PW-1:0]          out_pay
);

  localparam int PB = $clog2(W);
  localparam int DW = 4 + PW;                 // neg, zero, payload
  localparam int CW = 3 * MAG_BITS + DW;      // plus shifted magnitudes
  localparam int RW = ROOT_BITS + 4;
  localparam int NW = MAG_BITS + FRAC_BITS + 1;
  localparam logic [PB-1:0] PTOP = PB'(MAG_BITS - 1);

  // stage 1: magnitudes
  logic [2:0][W-1:0] mag1_r;
  logic [2:0]        neg1_r;
  logic [PW-1:0]     pay1_r;
  logic              vld1_r;
  // stage 2: maximum
  logic [W-1:0]      top2_r;
  logic [2:0][W-1:0] mag2_r;
  logic [2:0]        neg2_r;
  logic [PW-1:0]     pay2_r;
  logic              vld2_r;
  // stage 3: leading one
  logic [PB-1:0]     pos_nxt, pos3_r;
  logic              zero3_r;
  logic [2:0][W-1:0] mag3_r;
  logic [2:0]        neg3_r;
  logic [PW-1:0]     pay3_r;
  logic              vld3_r;
  // stage 4: aligned magnitudes
  logic [2:0][MAG_BITS-1:0] mn_nxt, mn4_r;
  logic [2:0]        neg4_r;
  logic              zero4_r;
  logic [PW-1:0]     pay4_r;
  logic              vld4_r;
  // stages 5, 6: squares and sum
  logic [2:0][2*MAG_BITS-1:0] sq5_r;
  logic [CW-1:0]     ctx5_r, ctx6_r;
  logic [SUM_BITS-1:0] sum6_r;
  logic              vld5_r, vld6_r;

  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < W; i++) begin
      if (top2_r[i]) begin
        pos_nxt = PB'(i);
      end
    end
  end

  always_comb begin
    logic [W+MAG_BITS-1:0] wide;
    for (int c = 0; c < 3; c++) begin
      if (pos3_r > PTOP) begin
        wide = {{MAG_BITS{1'b0}}, mag3_r[c]} >> (pos3_r - PTOP);
      end else begin
        wide = {{MAG_BITS{1'b0}}, mag3_r[c]} << (PTOP - pos3_r);
      end
      mn_nxt[c] = wide[MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        neg1_r[c] <= in_vec[c][W-1];
        mag1_r[c] <= in_vec[c][W-1] ? -in_vec[c] : in_vec[c];
      end
      pay1_r <= in_pay;

      top2_r <= (mag1_r[0] >= mag1_r[1]) ?
                ((mag1_r[0] >= mag1_r[2]) ? mag1_r[0] : mag1_r[2]) :
                ((mag1_r[1] >= mag1_r[2]) ? mag1_r[1] : mag1_r[2]);
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      pay2_r <= pay1_r;

      pos3_r  <= pos_nxt;
      zero3_r <= (top2_r == '0);
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      pay3_r  <= pay2_r;

      mn4_r   <= mn_nxt;
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
      pay4_r  <= pay3_r;

      for (int c = 0; c < 3; c++) begin
        sq5_r[c] <= mn4_r[c] * mn4_r[c];
      end
      ctx5_r <= {mn4_r, neg4_r, zero4_r, pay4_r};

      sum6_r <= SUM_BITS'(sq5_r[0]) + SUM_BITS'(sq5_r[1]) + SUM_BITS'(sq5_r[2]);
      ctx6_r <= ctx5_r;
    end
  end

  // integer square root, one result bit per stage
  logic [RW-1:0]        sr_rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] sr_root_r [ROOT_BITS];
  logic [SUM_BITS-1:0]  sr_op_r   [ROOT_BITS];
  logic [CW-1:0]        sr_ctx_r  [ROOT_BITS];
  logic                 sr_vld_r  [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    localparam int I = ROOT_BITS - 1 - k;
    logic [RW-1:0]        rem_i, r2, trial;
    logic [ROOT_BITS-1:0] root_i;
    logic [SUM_BITS-1:0]  op_i;
    logic [CW-1:0]        ctx_i;
    logic                 vld_i;
    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign op_i   = sum6_r;
      assign ctx_i  = ctx6_r;
      assign vld_i  = vld6_r;
    end else begin : g_next
      assign rem_i  = sr_rem_r[k-1];
      assign root_i = sr_root_r[k-1];
      assign op_i   = sr_op_r[k-1];
      assign ctx_i  = sr_ctx_r[k-1];
      assign vld_i  = sr_vld_r[k-1];
    end
    assign r2    = {rem_i[RW-3:0], op_i[2*I+1 -: 2]};
    assign trial = RW'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_vld_r[k] <= 1'b0;
      end else if (en) begin
        sr_vld_r[k] <= vld_i;
      end
      if (en) begin
        if (r2 >= trial) begin
          sr_rem_r[k]  <= r2 - trial;
          sr_root_r[k] <= {root_i[ROOT_BITS-2:0], 1'b1};
        end else begin
          sr_rem_r[k]  <= r2;
          sr_root_r[k] <= {root_i[ROOT_BITS-2:0], 1'b0};
        end
        sr_op_r[k]  <= op_i;
        sr_ctx_r[k] <= ctx_i;
      end
    end
  end

  // dividends: m * 2^30 + r/2
  logic [2:0][MAG_BITS-1:0] sr_mn;
  logic [NW-1:0]        dn_r [3];
  logic [ROOT_BITS-1:0] dr_r;
  logic [DW-1:0]        dctx_r;
  logic                 dvld_r;

  assign sr_mn = sr_ctx_r[ROOT_BITS-1][CW-1:DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= 1'b0;
    end else if (en) begin
      dvld_r <= sr_vld_r[ROOT_BITS-1];
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dn_r[c] <= NW'({sr_mn[c], {FRAC_BITS{1'b0}}}) +
                   NW'(sr_root_r[ROOT_BITS-1] >> 1);
      end
      dr_r   <= sr_root_r[ROOT_BITS-1];
      dctx_r <= sr_ctx_r[ROOT_BITS-1][DW-1:0];
    end
  end

  // restoring divide, one quotient bit per stage; quotient stays below 2^31
  logic [ROOT_BITS-1:0] dv_rem_r [QUO_BITS][3];
  logic [QUO_BITS-1:0]  dv_q_r   [QUO_BITS][3];
  logic [NW-1:0]        dv_n_r   [QUO_BITS][3];
  logic [ROOT_BITS-1:0] dv_d_r   [QUO_BITS];
  logic [DW-1:0]        dv_ctx_r [QUO_BITS];
  logic                 dv_vld_r [QUO_BITS];

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    localparam int B = QUO_BITS - 1 - j;
    logic [ROOT_BITS-1:0] rem_i [3];
    logic [QUO_BITS-1:0]  q_i   [3];
    logic [NW-1:0]        n_i   [3];
    logic [ROOT_BITS-1:0] d_i;
    logic [DW-1:0]        ctx_i;
    logic                 vld_i;
    if (j == 0) begin : g_first
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rem_i[c] = ROOT_BITS'(dn_r[c][NW-1:QUO_BITS]);
        assign q_i[c]   = '0;
        assign n_i[c]   = dn_r[c];
      end
      assign d_i   = dr_r;
      assign ctx_i = dctx_r;
      assign vld_i = dvld_r;
    end else begin : g_next
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rem_i[c] = dv_rem_r[j-1][c];
        assign q_i[c]   = dv_q_r[j-1][c];
        assign n_i[c]   = dv_n_r[j-1][c];
      end
      assign d_i   = dv_d_r[j-1];
      assign ctx_i = dv_ctx_r[j-1];
      assign vld_i = dv_vld_r[j-1];
    end

    always_ff @(posedge clk) begin
      logic [ROOT_BITS:0] r2;
      if (!rst_n) begin
        dv_vld_r[j] <= 1'b0;
      end else if (en) begin
        dv_vld_r[j] <= vld_i;
      end
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          r2 = {rem_i[c], n_i[c][B]};
          if (r2 >= {1'b0, d_i}) begin
            dv_rem_r[j][c] <= ROOT_BITS'(r2 - {1'b0, d_i});
            dv_q_r[j][c]   <= {q_i[c][QUO_BITS-2:0], 1'b1};
          end else begin
            dv_rem_r[j][c] <= r2[ROOT_BITS-1:0];
            dv_q_r[j][c]   <= {q_i[c][QUO_BITS-2:0], 1'b0};
          end
          dv_n_r[j][c] <= n_i[c];
        end
        dv_d_r[j]   <= d_i;
        dv_ctx_r[j] <= ctx_i;
      end
    end
  end

  // sign and zero-vector handling
  logic [2:0][DATA_W-1:0] u_r;
  logic [PW-1:0]          upay_r;
  logic                   uvld_r;
  logic [2:0]             fin_neg;
  logic                   fin_zero;

  assign fin_neg  = dv_ctx_r[QUO_BITS-1][DW-1 -: 3];
  assign fin_zero = dv_ctx_r[QUO_BITS-1][PW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uvld_r <= 1'b0;
    end else if (en) begin
      uvld_r <= dv_vld_r[QUO_BITS-1];
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        if (fin_zero) begin
          u_r[c] <= '0;
        end else if (fin_neg[c]) begin
          u_r[c] <= -DATA_W'(dv_q_r[QUO_BITS-1][c]);
        end else begin
          u_r[c] <= DATA_W'(dv_q_r[QUO_BITS-1][c]);
        end
      end
      upay_r <= dv_ctx_r[QUO_BITS-1][PW-1:0];
    end
  end

  assign out_valid = uvld_r;
  assign out_vec   = u_r;
  assign out_pay   = upay_r;

endmodule

### rtl/look_at_view_matrix_core.sv
// Look-at view matrix core.
// Input channel: in_valid/in_ready with in_data (eye, target, up in signed
// Q16.16). Result channel: out_valid/out_ready with out_data (side, true up
// and back rows in Q2.30, negated eye in saturated Q16.16). One result per
// request, in order.
// The latency is set by the three normalizers in series (each with a
// 32-stage square root and a 31-stage divide, one bit per stage), plus two
// cross product units and the input and output registers.
// Throughput: one request per cycle while the receiver does not stall.
// The receiver stalling (out_valid high, out_ready low) freezes the whole
// pipeline; in_ready drops in that cycle and nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// A zero-length axis yields a zero row; -2^31 eye coordinates negate to
// the largest positive value.
module look_at_view_matrix_core
  import lav_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lav_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lav_out_t out_data
);

  localparam int V3 = 3 * DATA_W;

  logic en;
  logic out_valid_r;
  lav_out_t out_data_r;

  assign en = !out_valid_r || out_ready;

  // input stage
  logic [2:0][DATA_W:0]   diff0_r;
  logic [2:0][DATA_W-1:0] up0_r, shift0_r;
  logic                   vld0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
    if (en) begin
      diff0_r[0] <= {in_data.eye_x[DATA_W-1], in_data.eye_x} -
                    {in_data.target_x[DATA_W-1], in_data.target_x};
      diff0_r[1] <= {in_data.eye_y[DATA_W-1], in_data.eye_y} -
                    {in_data.target_y[DATA_W-1], in_data.target_y};
      diff0_r[2] <= {in_data.eye_z[DATA_W-1], in_data.eye_z} -
                    {in_data.target_z[DATA_W-1], in_data.target_z};
      up0_r      <= {in_data.up_z, in_data.up_y, in_data.up_x};
      shift0_r   <= {sat_neg(in_data.eye_z), sat_neg(in_data.eye_y),
                     sat_neg(in_data.eye_x)};
    end
  end

  // back axis
  logic                   n1_vld;
  logic [2:0][DATA_W-1:0] back1;
  logic [2*V3-1:0]        n1_pay;

  lav_norm #(.W(DATA_W + 1), .PW(2 * V3)) u_norm_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld0_r),
    .in_vec    (diff0_r),
    .in_pay    ({up0_r, shift0_r}),
    .out_valid (n1_vld),
    .out_vec   (back1),
    .out_pay   (n1_pay)
  );

  // up x back
  logic                     c1_vld;
  logic [2:0][2*DATA_W-1:0] c1_vec;
  logic [2*V3-1:0]          c1_pay;

  lav_cross #(.PW(2 * V3)) u_cross_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n1_vld),
    .in_a      (n1_pay[2*V3-1:V3]),
    .in_b      (back1),
    .in_pay    ({back1, n1_pay[V3-1:0]}),
    .out_valid (c1_vld),
    .out_vec   (c1_vec),
    .out_pay   (c1_pay)
  );

  // side axis
  logic                   n2_vld;
  logic [2:0][DATA_W-1:0] side2;
  logic [2*V3-1:0]        n2_pay;

  lav_norm #(.W(2 * DATA_W), .PW(2 * V3)) u_norm_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c1_vld),
    .in_vec    (c1_vec),
    .in_pay    (c1_pay),
    .out_valid (n2_vld),
    .out_vec   (side2),
    .out_pay   (n2_pay)
  );

  // back x side
  logic                     c2_vld;
  logic [2:0][2*DATA_W-1:0] c2_vec;
  logic [3*V3-1:0]          c2_pay;

  lav_cross #(.PW(3 * V3)) u_cross_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n2_vld),
    .in_a      (n2_pay[2*V3-1:V3]),
    .in_b      (side2),
    .in_pay    ({n2_pay[2*V3-1:V3], side2, n2_pay[V3-1:0]}),
    .out_valid (c2_vld),
    .out_vec   (c2_vec),
    .out_pay   (c2_pay)
  );

  // true up axis
  logic                   n3_vld;
  logic [2:0][DATA_W-1:0] tup3;
  logic [3*V3-1:0]        n3_pay;
  logic [2:0][DATA_W-1:0] back3, side3, shift3;

  lav_norm #(.W(2 * DATA_W), .PW(3 * V3)) u_norm_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c2_vld),
    .in_vec    (c2_vec),
    .in_pay    (c2_pay),
    .out_valid (n3_vld),
    .out_vec   (tup3),
    .out_pay   (n3_pay)
  );

  assign back3  = n3_pay[3*V3-1:2*V3];
  assign side3  = n3_pay[2*V3-1:V3];
  assign shift3 = n3_pay[V3-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= n3_vld;
    end
    if (en) begin
      out_data_r.side_x    <= side3[0];
      out_data_r.side_y    <= side3[1];
      out_data_r.side_z    <= side3[2];
      out_data_r.true_up_x <= tup3[0];
      out_data_r.true_up_y <= tup3[1];
      out_data_r.true_up_z <= tup3[2];
      out_data_r.back_x    <= back3[0];
      out_data_r.back_y    <= back3[1];
      out_data_r.back_z    <= back3[2];
      out_data_r.shift_x   <= shift3[0];
      out_data_r.shift_y   <= shift3[1];
      out_data_r.shift_z   <= shift3[2];
    end
  end

  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // negation saturates, never wraps to the minimum
  a_shift_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.shift_x != S32_MIN && out_data.shift_y != S32_MIN &&
                   out_data.shift_z != S32_MIN))
    else $error("translation wrapped to minimum");

  // x components of the unit rows stay within one
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.back_x <= Q30_ONE && out_data.back_x >= -Q30_ONE &&
                   out_data.side_x <= Q30_ONE && out_data.side_x >= -Q30_ONE &&
                   out_data.true_up_x <= Q30_ONE && out_data.true_up_x >= -Q30_ONE))
    else $error("normalized component out of range");

  // a zero back axis forces zero side and true up rows
  a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.back_x == '0 && out_data.back_y == '0 &&
     out_data.back_z == '0) |->
    (out_data.side_x == '0 && out_data.side_y == '0 && out_data.side_z == '0 &&
     out_data.true_up_x == '0 && out_data.true_up_y == '0 &&
     out_data.true_up_z == '0))
    else $error("nonzero row from zero back axis");

endmodule

### tb/tb_top.sv
module tb_top;
  import lav_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 219;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1530;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // Expected view matrices, oldest first.
  class view_scoreboard;
    lav_out_t pending[$];
    int errors;

    static function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    static function automatic void unit_axis(input logic signed [63:0] v[3],
                                             output logic signed [63:0] u[3]);
      logic [63:0] m[3];
      logic [63:0] top, sum, r, q;
      int p;
      top = 0;
      sum = 0;
      p = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = v[i] < 0 ? 64'd0 - v[i] : v[i];
        if (m[i] > top) top = m[i];
      end
      if (top == 0) begin
        for (int i = 0; i < 3; i++) u[i] = 0;
        return;
      end
      while ((top >> p) > 1) p++;
      for (int i = 0; i < 3; i++) begin
        if (p > 30) m[i] = m[i] >> (p - 30);
        else m[i] = m[i] << (30 - p);
        sum += m[i] * m[i];
      end
      r = root64(sum);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 64'h4000_0000 + r / 2) / r;
        u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
      end
    endfunction

    static function automatic void cross3(input logic signed [63:0] a[3],
                                          input logic signed [63:0] b[3],
                                          output logic signed [63:0] c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function void note_request(lav_in_t r);
      logic signed [63:0] eye[3], up[3], d[3], bk[3], t[3], sd[3], tu[3];
      logic signed [31:0] ng[3];
      lav_out_t e;
      eye = '{r.eye_x, r.eye_y, r.eye_z};
      up = '{r.up_x, r.up_y, r.up_z};
      d[0] = eye[0] - r.target_x;
      d[1] = eye[1] - r.target_y;
      d[2] = eye[2] - r.target_z;
      unit_axis(d, bk);
      cross3(up, bk, t);
      unit_axis(t, sd);
      cross3(bk, sd, t);
      unit_axis(t, tu);
      for (int i = 0; i < 3; i++) begin
        ng[i] = eye[i] == -64'sd2147483648 ? 32'sh7fff_ffff : 32'(-eye[i]);
      end
      e.side_x = sd[0][31:0];
      e.side_y = sd[1][31:0];
      e.side_z = sd[2][31:0];
      e.true_up_x = tu[0][31:0];
      e.true_up_y = tu[1][31:0];
      e.true_up_z = tu[2][31:0];
      e.back_x = bk[0][31:0];
      e.back_y = bk[1][31:0];
      e.back_z = bk[2][31:0];
      e.shift_x = ng[0];
      e.shift_y = ng[1];
      e.shift_z = ng[2];
      pending.push_back(e);
    endfunction

    function void check_result(lav_out_t got);
      lav_out_t e;
      logic [31:0] ev[12], gv[12];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      ev = {>>{e}};
      gv = {>>{got}};
      for (int i = 0; i < 12; i++) begin
        if (ev[i] !== gv[i]) begin
          $display("%0t: field %0d expected %h actual %h", $realtime, i, ev[i], gv[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  lav_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  lav_out_t out_data;

  view_scoreboard sb = new();
  idle_mode_e mode = IDLE_NONE;
  bit hold_off = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  look_at_view_matrix_core i_dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      quiet_cycles <= (in_valid && in_ready) || (out_valid && out_ready) ? 0
                      : quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // receiver side
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (mode == IDLE_RECV || mode == IDLE_BOTH) out_ready <= $urandom_range(99) >= 75;
    else out_ready <= 1'b1;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return $signed($urandom_range(65535)) - 32768;
      default: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic lav_in_t rand_request();
    lav_in_t r;
    r.eye_x = rand_coord();
    r.eye_y = rand_coord();
    r.eye_z = rand_coord();
    r.target_x = rand_coord();
    r.target_y = rand_coord();
    r.target_z = rand_coord();
    r.up_x = rand_coord();
    r.up_y = rand_coord();
    r.up_z = rand_coord();
    case ($urandom_range(9))
      0: {r.target_x, r.target_y, r.target_z} = {r.eye_x, r.eye_y, r.eye_z};
      1: {r.up_x, r.up_y, r.up_z} = '0;
      2: begin
        // up along the view axis
        r.target_x = r.eye_x - r.up_x;
        r.target_y = r.eye_y - r.up_y;
        r.target_z = r.eye_z - r.up_z;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(lav_in_t r);
    if (mode == IDLE_SEND || mode == IDLE_BOTH) begin
      while ($urandom_range(99) < 75) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    lav_in_t r;
    lav_in_t directed[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    r = '0;
    r.eye_z = 32'h0005_0000;
    r.up_y = 32'h0001_0000;
    directed.push_back(r);
    directed.push_back('0);
    r.target_x = 32'h1234_0000;
    r.target_y = 32'h1234_0000;
    r.target_z = 32'h1234_0000;
    r.eye_x = 32'h8000_0000;
    r.eye_y = 32'h8000_0000;
    r.eye_z = 32'h8000_0000;
    directed.push_back(r);
    directed.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    directed.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h0,
                         32'h7fff_ffff, 32'h8000_0000, 32'h1,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    directed.push_back('{32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                         32'h0, 32'h1, 32'h0});
    directed.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 32'h0,
                         32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    directed.push_back('{32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                         32'h0001_0000, 32'h0, 32'h0});
    foreach (directed[i]) send_request(directed[i]);
    for (int i = 0; i < 12; i++) send_request(rand_request());
    in_valid <= 1'b0;
    drain();

    // long receiver hold-off while the sender keeps pushing
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 400; i++) send_request(rand_request());
    join
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      mode = idle_mode_e'(ph);
      for (int i = 0; i < N_RANDOM / 5; i++) send_request(rand_request());
    end
    mode = IDLE_NONE;
    for (int i = 0; i < N_RANDOM / 5; i++) send_request(rand_request());
    in_valid <= 1'b0;
    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
